[rtl/lct_pkg.sv]
// lct_pkg: shared widths, codes and the structs that pass between the
// cache cells and the controller of the LFU cache table.
// No dependencies.
package lct_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CAP_W   = 5;
  // index and age fields cover the largest table (256 entries)
  localparam int IDX_W   = 8;
  localparam int AGE_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_FILL
  } cmd_op_t;

  // record that travels down the row of cells, one cell per cycle
  typedef struct packed {
    logic               tok;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [AGE_W-1:0]   hit_age;
    logic [DATA_W-1:0]  hit_data;
    logic               vic_ok;
    logic [IDX_W-1:0]   vic_idx;
    logic [COUNT_W-1:0] vic_cnt;
    logic [AGE_W-1:0]   vic_age;
    logic               free_ok;
    logic [IDX_W-1:0]   free_idx;
  } scan_t;

  // update broadcast to every cell at commit
  typedef struct packed {
    cmd_op_t           op;
    logic              put;
    logic [IDX_W-1:0]  idx;
    logic              evict;
    logic [IDX_W-1:0]  vic_idx;
    logic [AGE_W-1:0]  ref_age;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

[rtl/lct_cell.sv]
// lct_cell: one cache entry (key, data, use count, recency age) plus one
// stage of the scan record that runs down the row. Depends on lct_pkg.
module lct_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lct_pkg::KEY_W-1:0] probe_key,
  input  lct_pkg::scan_t            scan_in,
  output lct_pkg::scan_t            scan_out,
  input  lct_pkg::cmd_t             cmd,
  output logic                      live
);
  import lct_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic               valid;
  logic [KEY_W-1:0]   ent_key;
  logic [DATA_W-1:0]  ent_data;
  logic [COUNT_W-1:0] count;
  logic [AGE_W-1:0]   age;
  scan_t              scan_next;

  assign live = valid;

  // fold this entry into the passing record
  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && valid && ent_key == probe_key) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_idx  = MY_IDX;
      scan_next.hit_age  = age;
      scan_next.hit_data = ent_data;
    end
    // lowest count wins, oldest among equal counts
    if (valid && (!scan_in.vic_ok || count < scan_in.vic_cnt ||
                  (count == scan_in.vic_cnt && age > scan_in.vic_age))) begin
      scan_next.vic_ok  = 1'b1;
      scan_next.vic_idx = MY_IDX;
      scan_next.vic_cnt = count;
      scan_next.vic_age = age;
    end
    if (!scan_in.free_ok && !valid) begin
      scan_next.free_ok  = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
    // token is control and clears on reset; the rest is payload
    if (rst) begin
      scan_next.tok = 1'b0;
    end
  end

  // scan stage register
  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  // entry update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_TOUCH: begin
          if (cmd.idx == MY_IDX) begin
            age <= '0;
            if (count != COUNT_MAX) begin
              count <= count + COUNT_W'(1);
            end
            if (cmd.put) begin
              ent_data <= cmd.data;
            end
          end else if (valid && age < cmd.ref_age) begin
            age <= age + AGE_W'(1);
          end
        end
        OP_FILL: begin
          if (cmd.idx == MY_IDX) begin
            valid    <= 1'b1;
            ent_key  <= probe_key;
            ent_data <= cmd.data;
            count    <= COUNT_W'(1);
            age      <= '0;
          end else if (cmd.evict && cmd.vic_idx == MY_IDX) begin
            valid <= 1'b0;
          end else if (valid && !(cmd.evict && age > cmd.ref_age)) begin
            // older than the victim: eviction and insert cancel out
            age <= age + AGE_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a touched entry is made the newest (age zero) and stays valid
  a_touch_age: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_TOUCH && cmd.idx == MY_IDX) |=> (age == '0 && valid))
    else $error("touched entry not made newest");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FILL && cmd.idx == MY_IDX) |=> (valid && ent_key == $past(probe_key)))
    else $error("filled entry not stored");

  a_tok_once: assert property (@(posedge clk) disable iff (rst)
    scan_out.tok |=> !scan_out.tok)
    else $error("scan token held for two cycles");

endmodule

[rtl/lfu_cache_table_top.sv]
// lfu_cache_table_top: LFU key-value cache with LRU tie-break, built as a
// row of lct_cell entries with a scan record passing down the row.
// Depends on lct_pkg and lct_cell.
//
//   channel   handshake             payload
//   -------   -------------------   ----------------------------------
//   input     in_valid / in_stall   func, key, value
//   output    out_valid / out_stall hit, read_value
//   config    cfg_we                cfg_wdata (capacity_in_use)
//
// An item runs from accept through the start register and the row to commit;
// a new word is accepted only in idle, once the last item has committed.
// The scan record moves one cell per cycle down the row of ENTRIES cells.
// Reset (rst, synchronous) empties the table and sets capacity to 16.
// The result register lets the next word be accepted while a result waits;
// a finished item holds in commit until the result register is free.
module lfu_cache_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic signed [31:0]         key,
  input  logic signed [31:0]         value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic signed [31:0]         read_value,
  input  logic                       cfg_we,
  input  logic [lct_pkg::CAP_W-1:0]  cfg_wdata
);
  import lct_pkg::*;

  localparam int UW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (UW > CAP_W) ? UW : CAP_W;

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic [CAP_W-1:0]   capacity;
  logic [UW-1:0]      entries_used;
  logic [UW-1:0]      entries_used_next;
  logic               func_q;
  logic [KEY_W-1:0]   key_q;
  logic [DATA_W-1:0]  value_q;
  logic               start;
  scan_t              rec;
  scan_t              seed;
  scan_t              chain [ENTRIES+1];
  cmd_t               cmd;
  logic [ENTRIES-1:0] live;
  logic               accept;
  logic               commit_go;
  logic               disabled;
  logic               full;
  logic               evict;
  logic               do_fill;
  logic [IDX_W-1:0]   slot;
  logic [CMPW-1:0]    used_w;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // held input word and scan launch
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      key_q   <= key;
      value_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept;
    end
  end

  always_comb begin
    seed     = '0;
    seed.tok = start;
  end

  // row of cells
  assign chain[0] = seed;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lct_cell #(
      .IDX     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_key (key_q),
      .scan_in   (chain[i]),
      .scan_out  (chain[i+1]),
      .cmd       (cmd),
      .live      (live[i])
    );
  end

  // finished record from the end of the row
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain[ENTRIES].tok) begin
      rec <= chain[ENTRIES];
    end
  end

  // control: state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control: next state, stall, commit
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    commit_go  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES].tok) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // commit decision from the record
  assign used_w   = CMPW'(entries_used);
  assign disabled = (capacity == '0);
  assign full     = (used_w >= CMPW'(capacity)) || (used_w >= CMPW'(ENTRIES));
  assign evict    = full && rec.vic_ok;
  assign do_fill  = !disabled && !rec.hit && func_q == FUNC_PUT && (evict || rec.free_ok);

  // first empty slot once the victim is gone
  always_comb begin
    if (evict && !(rec.free_ok && rec.free_idx < rec.vic_idx)) begin
      slot = rec.vic_idx;
    end else begin
      slot = rec.free_idx;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.put     = (func_q == FUNC_PUT);
    cmd.data    = value_q;
    cmd.vic_idx = rec.vic_idx;
    cmd.evict   = evict;
    cmd.idx     = rec.hit ? rec.hit_idx : slot;
    cmd.ref_age = rec.hit ? rec.hit_age : rec.vic_age;
    if (commit_go && !disabled && rec.hit) begin
      cmd.op = OP_TOUCH;
    end else if (commit_go && do_fill) begin
      cmd.op = OP_FILL;
    end
  end

  // occupancy: an insert after an eviction leaves it unchanged
  always_comb begin
    entries_used_next = entries_used;
    if (commit_go && do_fill && !evict) begin
      entries_used_next = entries_used + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else begin
      entries_used <= entries_used_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit_go) begin
      hit        <= !disabled && rec.hit;
      read_value <= (!disabled && rec.hit && func_q == FUNC_GET) ? rec.hit_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_used_match: assert property (@(posedge clk) disable iff (rst)
    32'(entries_used) == $countones(live))
    else $error("occupancy count out of step with valid entries");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES].tok |-> state == ST_SCAN)
    else $error("scan record finished outside scan");

  a_hit_no_grow: assert property (@(posedge clk) disable iff (rst)
    (commit_go && rec.hit) |=> $stable(entries_used))
    else $error("hit changed occupancy");

  a_pending_kept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && out_valid && out_stall) |=> (out_valid && $stable(read_value)))
    else $error("pending result overwritten");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for lfu_cache_table_top. An in-bench model of the
// LFU table with LRU tie-break predicts every result; results are checked in order.
// Depends on lct_pkg and lfu_cache_table_top.
module tb;
  import lct_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int LATENCY        = ENTRIES + 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_STALL_RUN  = 20;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } cache_req_t;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
  } cache_resp_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = FUNC_GET;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic signed [31:0] read_value;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;

  // model of the table
  logic [CAP_W-1:0]   cap_setting;
  logic               slot_valid [ENTRIES];
  logic [31:0]        slot_key   [ENTRIES];
  logic [31:0]        slot_data  [ENTRIES];
  logic [COUNT_W-1:0] slot_count [ENTRIES];
  int                 slot_age   [ENTRIES];
  int                 occupancy;

  cache_req_t  pending_words[$];
  cache_resp_t expected_results[$];
  int          mismatches = 0;

  lfu_cache_table_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .read_value(read_value),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the model and queue the result it must produce.
  task automatic predict_access(input cache_req_t w);
    cache_resp_t r;
    int lim, found, victim, slot, i;
    r.hit = 1'b0;
    r.read_value = '0;
    lim = (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
    if (lim != 0) begin
      found = -1;
      for (i = 0; i < ENTRIES; i++)
        if (found < 0 && slot_valid[i] && slot_key[i] == w.key) found = i;
      if (found >= 0) begin
        // hit: bump the count, move to the front of the recency order
        r.hit = 1'b1;
        if (w.func == FUNC_GET) r.read_value = slot_data[found];
        else slot_data[found] = w.value;
        if (slot_count[found] != COUNT_MAX) slot_count[found]++;
        for (i = 0; i < ENTRIES; i++)
          if (slot_valid[i] && i != found && slot_age[i] < slot_age[found]) slot_age[i]++;
        slot_age[found] = 0;
      end else if (w.func == FUNC_PUT) begin
        // full: drop the lowest count, oldest among equals
        if (occupancy >= lim) begin
          victim = -1;
          for (i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                (slot_count[i] == slot_count[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            for (i = 0; i < ENTRIES; i++)
              if (slot_valid[i] && i != victim && slot_age[i] > slot_age[victim])
                slot_age[i]--;
            slot_valid[victim] = 1'b0;
            if (occupancy > 0) occupancy--;
          end
        end
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_valid[i]) slot = i;
        if (slot >= 0) begin
          for (i = 0; i < ENTRIES; i++)
            if (slot_valid[i]) slot_age[i]++;
          slot_valid[slot] = 1'b1;
          slot_key[slot]   = w.key;
          slot_data[slot]  = w.value;
          slot_count[slot] = 1;
          slot_age[slot]   = 0;
          occupancy++;
        end
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic add_word(input logic f, input logic [31:0] k, input logic [31:0] v);
    cache_req_t w;
    w.func  = f;
    w.key   = k;
    w.value = v;
    pending_words.push_back(w);
  endtask

  // Capacity writes only happen with the table idle.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    cap_setting = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // 32-bit pattern biased toward the extremes
  function automatic logic [31:0] pick_word32();
    if ($urandom_range(0, 3) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return '0;
      default: return ALL_ONES;
    endcase
  endfunction

  // Word driver: bursts of random length, random gaps between them.
  logic drv_sending;
  int   burst_left = 1;
  int   gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drv_sending = in_valid;
      if (in_valid && !in_stall) begin
        predict_access(pending_words.pop_front());
        drv_sending = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (!drv_sending && pending_words.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          func  <= pending_words[0].func;
          key   <= pending_words[0].key;
          value <= pending_words[0].value;
          drv_sending = 1'b1;
        end
      end
      in_valid <= drv_sending;
    end
  end

  // Result monitor and receiver stall pattern.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_run = 0;
  logic        mon_stall;
  cache_resp_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hit %0b read_value %h", hit, read_value);
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit || read_value !== want.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit %0b read_value %h, got hit %0b read_value %h",
                       want.hit, want.read_value, hit, read_value);
          end
        end
      end
      if (mode_left <= 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_LIGHT:    mon_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    mon_stall = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: mon_stall = (mode_left % 5) < 2;
        default:        mon_stall = 1'b0;
      endcase
      if (stall_run >= MAX_STALL_RUN) mon_stall = 1'b0;
      stall_run = mon_stall ? stall_run + 1 : 0;
      out_stall <= mon_stall;
    end
  end

  // Watchdog: too long without any accepted word, result or capacity write ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    logic [31:0]      key_pool[$];
    logic [31:0]      k;
    int               lim, n;

    cap_setting = CAP_RESET;
    occupancy = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_data[i]  = '0;
      slot_count[i] = '0;
      slot_age[i]   = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty miss, key/value extremes, update, get ignoring value
    set_capacity(5'd16);
    add_word(FUNC_GET, '0, ALL_ONES);
    add_word(FUNC_PUT, KEY_MIN, KEY_MAX);
    add_word(FUNC_PUT, KEY_MAX, KEY_MIN);
    add_word(FUNC_PUT, '0, ALL_ONES);
    add_word(FUNC_PUT, ALL_ONES, '0);
    add_word(FUNC_GET, KEY_MIN, '0);
    add_word(FUNC_GET, KEY_MAX, ALL_ONES);
    add_word(FUNC_GET, '0, '0);
    add_word(FUNC_GET, ALL_ONES, KEY_MAX);
    add_word(FUNC_PUT, '0, 32'h1234_5678);
    add_word(FUNC_GET, '0, 32'hA5A5_5A5A);
    drain();

    // capacity dropped below occupancy: inserts replace, LFU then LRU
    set_capacity(5'd2);
    add_word(FUNC_PUT, 32'd5, 32'd55);
    add_word(FUNC_GET, 32'd5, '0);
    add_word(FUNC_PUT, 32'd6, 32'd66);
    add_word(FUNC_GET, 32'd5, '0);
    drain();

    // disabled table answers miss and keeps its contents
    set_capacity(5'd0);
    add_word(FUNC_GET, '0, '0);
    add_word(FUNC_PUT, 32'd7, 32'd77);
    add_word(FUNC_GET, 32'd7, '0);
    drain();

    // capacity above the table size saturates
    set_capacity(5'd31);
    add_word(FUNC_GET, 32'd7, '0);
    add_word(FUNC_GET, '0, '0);
    drain();

    // random phases over a spread of capacities
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd12, 5'd2, 5'd17, 5'd16, 5'd7};
    phase_caps[8] = $urandom_range(0, 31);
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      lim = (phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
      n = lim + $urandom_range(1, 6);
      key_pool.delete();
      repeat (n) key_pool.push_back(pick_word32());
      repeat (75) begin
        // hot keys at the low end of the pool, a few keys from anywhere
        if ($urandom_range(0, 9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(0, $urandom_range(0, n - 1))];
        add_word(($urandom_range(0, 9) < 6) ? FUNC_PUT : FUNC_GET, k,
                 ($urandom_range(0, 7) == 0) ? pick_word32() : $urandom());
      end
      drain();
    end

    mismatches += expected_results.size();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/lct_pkg.sv
rtl/lct_cell.sv
rtl/lfu_cache_table_top.sv
dv/tb.sv
